// ===== rtl/assert_macros.svh =====
// Assertion shorthands for the HSV selector RTL.
// Expects clk and active-low rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/hsvsel_pkg.sv =====
// Shared types and constants for the HSV range pixel selector.
// No dependencies.
`default_nettype none

package hsvsel_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HUE_LOW    = 3'd0,
        REG_HUE_HIGH   = 3'd1,
        REG_SAT_LOW    = 3'd2,
        REG_SAT_HIGH   = 3'd3,
        REG_VAL_LOW    = 3'd4,
        REG_VAL_HIGH   = 3'd5,
        REG_MARK_COLOR = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [14:0] hue_low;
        logic [14:0] hue_high;
        logic [12:0] sat_low;
        logic [12:0] sat_high;
        logic [7:0]  val_low;
        logic [7:0]  val_high;
        logic [31:0] mark_color;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        hue_low:    15'd0,
        hue_high:   15'd23040,
        sat_low:    13'd0,
        sat_high:   13'd4096,
        val_low:    8'd0,
        val_high:   8'd255,
        mark_color: 32'hffff73df
    };

    // Hue sector multiplier k: hue numerator is 3840 * (k*d + diff).
    localparam logic [2:0] SECT_RED  = 3'd0;
    localparam logic [2:0] SECT_GRN  = 3'd2;
    localparam logic [2:0] SECT_BLU  = 3'd4;
    localparam logic [2:0] SECT_WRAP = 3'd6;

    // 2 * 3840: hue numerator step in doubled units
    localparam logic [24:0] HUE_STEP2 = 25'd7680;

endpackage

`default_nettype wire

// ===== rtl/hsv_range_pixel_selector_core.sv =====
// HSV range pixel selector, top level: four-stage classification pipeline.
// Depends on hsvsel_pkg, hsvsel_cfg_regs and assert_macros.svh.
`default_nettype none

// Classifies one ABGR pixel per clock. Each pixel is converted to hue
// (1/64 degree), saturation (Q0.12) and value (max byte); a pixel whose three
// components all lie inside the inclusive bounds leaves as the mark colour with
// tuser set, any other pixel leaves unchanged with tuser clear. Grey pixels
// (max equal to min) are never selected. Each pixel passes the four register
// stages (extremes and sector, numerator, bound products, compare); one pixel
// per clock is taken while the output is not stalled, and each stage holds
// while the stage after it is full and stalled. No division is done: each
// rounded quotient bound is checked by comparing the numerator against the
// bound times the divisor.
module hsv_range_pixel_selector_core
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // input stream
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [31:0]                        s_axis_tdata,  // [31:0] pixel_in
    // output stream
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [31:0]                             m_axis_tdata,  // [31:0] pixel_out
    output logic                                    m_axis_tuser,  // [0] selected
    // configuration
    input  wire logic                               cfg_we,
    input  wire logic [hsvsel_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [hsvsel_pkg::CFG_DATA_W-1:0]  cfg_data
);

    hsvsel_pkg::cfg_t cfg;

    hsvsel_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // stage enables: a stage loads when empty or when the next one moves on
    logic en1, en2, en3, en4;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;

    assign en4 = !out_valid_reg || m_axis_tready;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;

    assign s_axis_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // ---------------- stage 1: extremes, sector, channel difference
    logic [7:0]        px_r, px_g, px_b;
    logic              red_max, grn_max;
    logic [7:0]        s1_mx_next, s1_mn_next;
    logic [2:0]        s1_k_next;
    logic signed [8:0] s1_diff_next;

    logic [31:0]       s1_pix_reg;
    logic [7:0]        s1_mx_reg, s1_mn_reg;
    logic [2:0]        s1_k_reg;
    logic signed [8:0] s1_diff_reg;

    assign px_r = s_axis_tdata[7:0];
    assign px_g = s_axis_tdata[15:8];
    assign px_b = s_axis_tdata[23:16];

    // ties: red beats green, green beats blue
    assign red_max = (px_r >= px_g) && (px_r >= px_b);
    assign grn_max = !red_max && (px_g >= px_b);

    always_comb
    begin
        s1_mn_next = px_r;
        if (px_g < s1_mn_next)
        begin
            s1_mn_next = px_g;
        end
        if (px_b < s1_mn_next)
        begin
            s1_mn_next = px_b;
        end

        if (red_max)
        begin
            s1_mx_next   = px_r;
            s1_diff_next = $signed({1'b0, px_g}) - $signed({1'b0, px_b});
            // negative hue wraps a full turn: 6 sectors
            s1_k_next    = (px_g < px_b) ? hsvsel_pkg::SECT_WRAP : hsvsel_pkg::SECT_RED;
        end
        else if (grn_max)
        begin
            s1_mx_next   = px_g;
            s1_diff_next = $signed({1'b0, px_b}) - $signed({1'b0, px_r});
            s1_k_next    = hsvsel_pkg::SECT_GRN;
        end
        else
        begin
            s1_mx_next   = px_b;
            s1_diff_next = $signed({1'b0, px_r}) - $signed({1'b0, px_g});
            s1_k_next    = hsvsel_pkg::SECT_BLU;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_pix_reg  <= s_axis_tdata;
            s1_mx_reg   <= s1_mx_next;
            s1_mn_reg   <= s1_mn_next;
            s1_k_reg    <= s1_k_next;
            s1_diff_reg <= s1_diff_next;
        end
    end

    // ---------------- stage 2: chroma d and sector numerator M = k*d + diff
    logic [7:0]         s2_d_next;
    logic [10:0]        s2_kd;
    logic signed [11:0] s2_m_full;

    logic [31:0]        s2_pix_reg;
    logic [7:0]         s2_d_reg, s2_mx_reg;
    logic [10:0]        s2_m_reg;
    logic               s2_chroma_reg;

    assign s2_d_next = s1_mx_reg - s1_mn_reg;
    assign s2_kd     = 11'(s1_k_reg) * 11'(s2_d_next);
    assign s2_m_full = $signed({1'b0, s2_kd}) + $signed({{3{s1_diff_reg[8]}}, s1_diff_reg});

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_pix_reg    <= s1_pix_reg;
            s2_d_reg      <= s2_d_next;
            s2_mx_reg     <= s1_mx_reg;
            s2_m_reg      <= s2_m_full[10:0];
            s2_chroma_reg <= (s2_d_next != 8'd0);
        end
    end

    // ---------------- stage 3: numerators and bound products
    // hue = floor(X / 2d), X = 7680*M + d; sat = floor(Y / 2mx), Y = 8192*d + mx
    logic [15:0] hue_high_p1;
    logic [13:0] sat_high_p1;
    logic [24:0] s3_hue_x_next, s3_hue_lo_next, s3_hue_hi_next;
    logic [22:0] s3_sat_x_next, s3_sat_lo_next, s3_sat_hi_next;

    logic [31:0] s3_pix_reg;
    logic [24:0] s3_hue_x_reg, s3_hue_lo_reg, s3_hue_hi_reg;
    logic [22:0] s3_sat_x_reg, s3_sat_lo_reg, s3_sat_hi_reg;
    logic [7:0]  s3_mx_reg;
    logic        s3_chroma_reg;

    assign hue_high_p1 = {1'b0, cfg.hue_high} + 16'd1;
    assign sat_high_p1 = {1'b0, cfg.sat_high} + 14'd1;

    assign s3_hue_x_next  = 25'(s2_m_reg) * hsvsel_pkg::HUE_STEP2 + 25'(s2_d_reg);
    assign s3_hue_lo_next = 25'({cfg.hue_low, 1'b0}) * 25'(s2_d_reg);
    assign s3_hue_hi_next = 25'({hue_high_p1, 1'b0}) * 25'(s2_d_reg);
    assign s3_sat_x_next  = 23'({s2_d_reg, 13'd0}) + 23'(s2_mx_reg);
    assign s3_sat_lo_next = 23'({cfg.sat_low, 1'b0}) * 23'(s2_mx_reg);
    assign s3_sat_hi_next = 23'({sat_high_p1, 1'b0}) * 23'(s2_mx_reg);

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_pix_reg    <= s2_pix_reg;
            s3_hue_x_reg  <= s3_hue_x_next;
            s3_hue_lo_reg <= s3_hue_lo_next;
            s3_hue_hi_reg <= s3_hue_hi_next;
            s3_sat_x_reg  <= s3_sat_x_next;
            s3_sat_lo_reg <= s3_sat_lo_next;
            s3_sat_hi_reg <= s3_sat_hi_next;
            s3_mx_reg     <= s2_mx_reg;
            s3_chroma_reg <= s2_chroma_reg;
        end
    end

    // ---------------- stage 4: bound compares and output select
    logic        out_sel_next;
    logic [31:0] out_pix_next;
    logic [31:0] out_pix_reg;
    logic        out_sel_reg;

    assign out_sel_next = s3_chroma_reg
                       && (s3_hue_x_reg >= s3_hue_lo_reg) && (s3_hue_x_reg < s3_hue_hi_reg)
                       && (s3_sat_x_reg >= s3_sat_lo_reg) && (s3_sat_x_reg < s3_sat_hi_reg)
                       && (s3_mx_reg >= cfg.val_low) && (s3_mx_reg <= cfg.val_high);
    assign out_pix_next = out_sel_next ? cfg.mark_color : s3_pix_reg;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            out_pix_reg <= out_pix_next;
            out_sel_reg <= out_sel_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pix_reg;
    assign m_axis_tuser  = out_sel_reg;

    // ---------------- assertions
`include "assert_macros.svh"

    `ASSERT_NEXT(a_grey_never_selected, s3_valid_reg && en4 && !s3_chroma_reg, !out_sel_reg, "grey pixel flagged as selected")
    `ASSERT_NEXT(a_stage3_holds, s3_valid_reg && !en4, s3_valid_reg && $stable(s3_pix_reg), "stage 3 item lost or changed under stall")
    `ASSERT_IMPL(a_full_backpressure, out_valid_reg && !m_axis_tready && s1_valid_reg && s2_valid_reg && s3_valid_reg, !s_axis_tready, "input taken while pipeline full and stalled")

endmodule

`default_nettype wire

// ===== rtl/hsvsel_cfg_regs.sv =====
// Configuration register bank for the HSV selector.
// Depends on hsvsel_pkg.
`default_nettype none

module hsvsel_cfg_regs
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [hsvsel_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [hsvsel_pkg::CFG_DATA_W-1:0]  cfg_data,
    output hsvsel_pkg::cfg_t                        cfg
);

    hsvsel_pkg::cfg_t cfg_reg;
    hsvsel_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (hsvsel_pkg::cfg_index_t'(cfg_index))
                hsvsel_pkg::REG_HUE_LOW:    cfg_next.hue_low    = cfg_data[14:0];
                hsvsel_pkg::REG_HUE_HIGH:   cfg_next.hue_high   = cfg_data[14:0];
                hsvsel_pkg::REG_SAT_LOW:    cfg_next.sat_low    = cfg_data[12:0];
                hsvsel_pkg::REG_SAT_HIGH:   cfg_next.sat_high   = cfg_data[12:0];
                hsvsel_pkg::REG_VAL_LOW:    cfg_next.val_low    = cfg_data[7:0];
                hsvsel_pkg::REG_VAL_HIGH:   cfg_next.val_high   = cfg_data[7:0];
                hsvsel_pkg::REG_MARK_COLOR: cfg_next.mark_color = cfg_data[31:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= hsvsel_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire
